>>> src/chu_pkg.sv
// -----------------------------------------------------------------------------
// chu_pkg
// Shared defaults and controller/datapath handshake types for the
// Catmull-Rom upsampler.
// -----------------------------------------------------------------------------
package chu_pkg;

  // default configuration
  localparam int DefaultSteps      = 20;
  localparam int DefaultSampleBits = 16;

  // fraction bits of the interpolation position t
  localparam int TFracBits = 16;

  // commands from the controller to the datapath
  typedef struct packed {
    logic shift;  // shift accepted sample into the window
    logic start;  // latch segment coefficients, restart t
    logic issue;  // launch one interpolation step
    logic last;   // the launched step ends the segment
  } chu_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic adv;    // pipeline moves this cycle
    logic busy;   // steps still in flight before the output register
  } chu_sts_t;

endpackage

>>> src/chu_in_if.sv
// -----------------------------------------------------------------------------
// chu_in_if
// Input sample channel: valid/ready with one signed sample per transfer.
// -----------------------------------------------------------------------------
interface chu_in_if #(
  parameter int SampleBits = chu_pkg::DefaultSampleBits
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

>>> src/chu_out_if.sv
// -----------------------------------------------------------------------------
// chu_out_if
// Output channel: valid/ready with an interpolated value and segment end flag.
// -----------------------------------------------------------------------------
interface chu_out_if #(
  parameter int SampleBits = chu_pkg::DefaultSampleBits
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] value;
  logic                         last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

>>> src/chu_ctrl.sv
// -----------------------------------------------------------------------------
// chu_ctrl
// Controller: tracks window fill, sequences the interpolation steps of a
// segment and waits for the pipeline to drain before the next sample.
// -----------------------------------------------------------------------------
module chu_ctrl #(
  parameter int Steps = chu_pkg::DefaultSteps
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output chu_pkg::chu_cmd_t cmd_o,
  input  chu_pkg::chu_sts_t sts_i
);
  import chu_pkg::*;

  localparam int CntW = $clog2(Steps);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRun   = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;

  localparam logic [1:0] FillFull = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [1:0]      fill_q, fill_d;
  logic [CntW-1:0] step_q, step_d;
  logic            accept;
  logic            step_last;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i & in_ready_o;
  assign step_last  = (step_q == CntW'(Steps - 1));

  // next state and commands
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    step_d      = step_q;
    cmd_o       = '0;
    cmd_o.shift = accept;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (fill_q == FillFull) begin
            cmd_o.start = 1'b1;
            step_d      = '0;
            state_d     = StRun;
          end else begin
            fill_d = fill_q + 2'd1;
          end
        end
      end
      StRun: begin
        if (sts_i.adv) begin
          cmd_o.issue = 1'b1;
          cmd_o.last  = step_last;
          step_d      = step_q + CntW'(1);
          if (step_last) begin
            state_d = StDrain;
          end
        end
      end
      StDrain: begin
        if (!sts_i.busy) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q  <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      step_q  <= step_d;
    end
  end

endmodule

>>> src/chu_datapath.sv
// -----------------------------------------------------------------------------
// chu_datapath
// Sample window, segment coefficients, t generator and a six-stage Horner
// pipeline (three multiply/round-add pairs) ending in the output register.
// -----------------------------------------------------------------------------
module chu_datapath #(
  parameter int Steps      = chu_pkg::DefaultSteps,
  parameter int SampleBits = chu_pkg::DefaultSampleBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  chu_pkg::chu_cmd_t            cmd_i,
  output chu_pkg::chu_sts_t            sts_o,
  input  logic signed [SampleBits-1:0] sample_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic signed [SampleBits-1:0] value_o,
  output logic                         last_o
);
  import chu_pkg::*;

  // coefficient, Horner accumulator, product and rounded result widths
  localparam int KW   = SampleBits + 5;
  localparam int HW   = SampleBits + 15;
  localparam int TW   = TFracBits + 1;
  localparam int PW   = HW + TW + 1;
  localparam int VW   = HW - 9;
  localparam int ExtW = HW - KW - 8;

  // t = i * 2^16 / Steps rounded half up, stepped as quotient and remainder
  localparam int TOne = 2 ** (TFracBits + 1);
  localparam int TwoS = 2 * Steps;
  localparam int QInc = TOne / TwoS;
  localparam int RInc = TOne % TwoS;
  localparam int RW   = $clog2(2 * TwoS);

  localparam logic signed [PW-1:0] RndQ = PW'(1) <<< (TFracBits - 1);
  localparam logic signed [HW-1:0] RndV = HW'(256);
  localparam logic signed [VW-1:0] VMax =
    {{(VW - SampleBits + 1){1'b0}}, {(SampleBits - 1){1'b1}}};
  localparam logic signed [VW-1:0] VMin =
    {{(VW - SampleBits + 1){1'b1}}, {(SampleBits - 1){1'b0}}};

  logic signed [SampleBits-1:0] win_q [3];
  logic signed [KW-1:0] ax, bx, cx, dx;
  logic signed [KW-1:0] k0_q, k1_q, k2_q, k3_q;

  logic [TW-1:0] t_q;
  logic [RW-1:0] r_q, r_sum;

  logic                 adv;
  logic [5:0]           v_q;
  logic [5:0]           l_q;
  logic [TW-1:0]        ts_q [4];
  logic signed [HW-1:0] h0;
  logic signed [PW-1:0] p1_q, p2_q, p3_q;
  logic signed [PW-1:0] r1, r2, r3;
  logic signed [HW-1:0] h1_q, h2_q, h3_q;
  logic signed [HW-1:0] r4;
  logic signed [VW-1:0] vr;
  logic signed [SampleBits-1:0] vsat;
  logic                 out_valid_q;
  logic                 out_last_q;
  logic signed [SampleBits-1:0] out_value_q;

  // sign-extend a coefficient into Q.8 accumulator format
  function automatic logic signed [HW-1:0] q8(input logic signed [KW-1:0] k);
    q8 = {{ExtW{k[KW-1]}}, k, 8'b0};
  endfunction

  // operands of the new segment: held window plus incoming sample
  assign ax = KW'(win_q[0]);
  assign bx = KW'(win_q[1]);
  assign cx = KW'(win_q[2]);
  assign dx = KW'(sample_i);

  // sample window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q[0] <= '0;
      win_q[1] <= '0;
      win_q[2] <= '0;
    end else if (cmd_i.shift) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= sample_i;
    end
  end

  // doubled polynomial coefficients of the segment
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      k0_q <= bx <<< 1;
      k1_q <= cx - ax;
      k2_q <= (ax <<< 1) - (bx <<< 2) - bx + (cx <<< 2) - dx;
      k3_q <= (bx <<< 1) + bx - (cx <<< 1) - cx + dx - ax;
    end
  end

  // t generator
  assign r_sum = r_q + RW'(RInc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q <= '0;
      r_q <= '0;
    end else if (cmd_i.start) begin
      t_q <= '0;
      r_q <= RW'(Steps);
    end else if (cmd_i.issue) begin
      if (r_sum >= RW'(TwoS)) begin
        r_q <= r_sum - RW'(TwoS);
        t_q <= t_q + TW'(QInc + 1);
      end else begin
        r_q <= r_sum;
        t_q <= t_q + TW'(QInc);
      end
    end
  end

  // pipeline advances unless the output register is stalled
  assign adv   = ~out_valid_q | ready_i;
  assign sts_o = '{adv: adv, busy: |v_q};

  // Horner steps: multiply by t, then round and add the next coefficient
  assign h0 = q8(k3_q);
  assign r1 = p1_q + RndQ;
  assign r2 = p2_q + RndQ;
  assign r3 = p3_q + RndQ;
  assign r4 = h3_q + RndV;
  assign vr = r4[HW-1:9];

  // saturate to the sample range
  always_comb begin
    if (vr > VMax) begin
      vsat = VMax[SampleBits-1:0];
    end else if (vr < VMin) begin
      vsat = VMin[SampleBits-1:0];
    end else begin
      vsat = vr[SampleBits-1:0];
    end
  end

  // stage valid bits and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v_q         <= {v_q[4:0], cmd_i.issue};
      out_valid_q <= v_q[5];
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      l_q   <= {l_q[4:0], cmd_i.last};
      ts_q[0] <= t_q;
      ts_q[1] <= ts_q[0];
      ts_q[2] <= ts_q[1];
      ts_q[3] <= ts_q[2];
      p1_q  <= h0 * $signed({1'b0, t_q});
      h1_q  <= r1[HW+15:16] + q8(k2_q);
      p2_q  <= h1_q * $signed({1'b0, ts_q[1]});
      h2_q  <= r2[HW+15:16] + q8(k1_q);
      p3_q  <= h2_q * $signed({1'b0, ts_q[3]});
      h3_q  <= r3[HW+15:16] + q8(k0_q);
      out_value_q <= vsat;
      out_last_q  <= l_q[5];
    end
  end

  assign valid_o = out_valid_q;
  assign value_o = out_value_q;
  assign last_o  = out_last_q;

endmodule

>>> src/cubic_hermite_upsampler_top.sv
// -----------------------------------------------------------------------------
// cubic_hermite_upsampler_top
// Streaming Catmull-Rom upsampler, Steps outputs per input sample.
// -----------------------------------------------------------------------------
// The first three samples after reset only fill the window. Every later sample
// starts a segment of Steps interpolated values between the two middle
// samples of the window; last marks the final value of a segment. For each
// segment the block takes the sample and latches the coefficients, issues the
// Steps interpolation steps into the six-stage Horner pipeline and then waits
// until the controller sees the pipeline empty before the next sample is
// taken. The output register may still hold the final value of a segment
// while the next sample is accepted; stalls on the output stall the whole
// pipeline.
module cubic_hermite_upsampler_top #(
  parameter int Steps      = chu_pkg::DefaultSteps,
  parameter int SampleBits = chu_pkg::DefaultSampleBits
) (
  input logic       clk_i,
  input logic       rst_ni,
  chu_in_if.sink    in_i,
  chu_out_if.source out_o
);
  import chu_pkg::*;

  chu_cmd_t cmd;
  chu_sts_t sts;

  // controller
  chu_ctrl #(
    .Steps(Steps)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  // datapath
  chu_datapath #(
    .Steps     (Steps),
    .SampleBits(SampleBits)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .sample_i(in_i.sample),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .value_o (out_o.value),
    .last_o  (out_o.last)
  );

endmodule

>>> src/chu_checker.sv
// -----------------------------------------------------------------------------
// chu_checker
// Port-level checks of the upsampler: window fill, segment framing and
// output stall behavior.
// -----------------------------------------------------------------------------
module chu_checker #(
  parameter int Steps      = chu_pkg::DefaultSteps,
  parameter int SampleBits = chu_pkg::DefaultSampleBits
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [SampleBits-1:0] out_value_i,
  input logic                  out_last_i
);
  localparam int CntW = $clog2(Steps);

  logic [2:0]      seen_q;
  logic [CntW-1:0] ocnt_q;

  // inputs seen, saturating at four
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (in_valid_i && in_ready_i && seen_q != 3'd4) begin
      seen_q <= seen_q + 3'd1;
    end
  end

  // position of the next output transfer within its segment
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q <= '0;
    end else if (out_valid_i && out_ready_i) begin
      if (ocnt_q == CntW'(Steps - 1)) begin
        ocnt_q <= '0;
      end else begin
        ocnt_q <= ocnt_q + CntW'(1);
      end
    end
  end

  // no output until four samples have arrived
  a_no_early_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> seen_q == 3'd4)
    else $error("output before the window is full");

  // last flag on every Steps-th output transfer
  a_last_framing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i) |-> (out_last_i == (ocnt_q == CntW'(Steps - 1))))
    else $error("last flag out of step with segment length");

  // no new sample while a segment is still being emitted
  a_busy_in_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_last_i) |-> !in_ready_i)
    else $error("input ready in the middle of a segment");

  // stalled output holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_value_i) && $stable(out_last_i)))
    else $error("stalled output changed");

endmodule

bind cubic_hermite_upsampler_top chu_checker #(
  .Steps     (Steps),
  .SampleBits(SampleBits)
) u_chu_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_value_i(out_o.value),
  .out_last_i (out_o.last)
);
